// ===== hw/rtl/drc_pkg.sv =====
// ----------------------------------------------------------------------------
// drc_pkg
// Shared types and constants of the dynamic range compressor.
// ----------------------------------------------------------------------------
package drc_pkg;

  localparam int unsigned MaxChannels = 8;
  localparam logic [30:0] OneQ30      = 31'h4000_0000;

  typedef enum logic [3:0] {
    REG_THRESHOLD     = 4'd0,
    REG_RATIO         = 4'd1,
    REG_ATTACK        = 4'd2,
    REG_RELEASE       = 4'd3,
    REG_MAKEUP        = 4'd4,
    REG_CHANNEL_COUNT = 4'd5,
    REG_ENABLE        = 4'd6,
    REG_SAMPLE_FORMAT = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [30:0] threshold;
    logic [6:0]  ratio;
    logic [30:0] atk_coef;
    logic [30:0] rel_coef;
    logic [30:0] makeup;
    logic [3:0]  channel_count;
    logic        enable;
    logic        sample_format;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] sample_0;
    logic signed [31:0] sample_1;
    logic signed [31:0] sample_2;
    logic signed [31:0] sample_3;
    logic signed [31:0] sample_4;
    logic signed [31:0] sample_5;
    logic signed [31:0] sample_6;
    logic signed [31:0] sample_7;
    logic               block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_sample_0;
    logic signed [31:0] out_sample_1;
    logic signed [31:0] out_sample_2;
    logic signed [31:0] out_sample_3;
    logic signed [31:0] out_sample_4;
    logic signed [31:0] out_sample_5;
    logic signed [31:0] out_sample_6;
    logic signed [31:0] out_sample_7;
    logic               block_end_out;
  } out_item_t;

  // classified frame handed from front to back
  typedef struct packed {
    logic [MaxChannels-1:0][31:0] smp;
    logic [30:0]                  peak;
    logic                         bypass;
    logic                         block_end;
  } work_t;

endpackage

// ===== hw/rtl/drc_front.sv =====
// ----------------------------------------------------------------------------
// drc_front
// Converts the incoming frame to Q31 (16-bit samples are only sign-extended while the
// compressor is disabled), masks inactive channels, finds the peak.
module drc_front (
  input  drc_pkg::cfg_t     cfg_i,
  input  drc_pkg::in_item_t item_i,
  output drc_pkg::work_t    work_o
);

  logic [drc_pkg::MaxChannels-1:0][31:0] raw;
  logic [drc_pkg::MaxChannels-1:0][31:0] val;
  logic [drc_pkg::MaxChannels-1:0][30:0] mag;
  logic [30:0] peak;
  logic        fmt16;

  assign raw[0] = item_i.sample_0;
  assign raw[1] = item_i.sample_1;
  assign raw[2] = item_i.sample_2;
  assign raw[3] = item_i.sample_3;
  assign raw[4] = item_i.sample_4;
  assign raw[5] = item_i.sample_5;
  assign raw[6] = item_i.sample_6;
  assign raw[7] = item_i.sample_7;

  assign fmt16 = !cfg_i.sample_format;

  always_comb begin
    peak = '0;
    for (int c = 0; c < drc_pkg::MaxChannels; c++) begin
      if (fmt16) begin
        val[c] = cfg_i.enable ? {raw[c][15:0], 16'h0000}
                              : {{16{raw[c][15]}}, raw[c][15:0]};
      end else begin
        val[c] = raw[c];
      end
      if (4'(c) >= cfg_i.channel_count) begin
        val[c] = '0;
      end
      // saturating magnitude: -2^31 maps to 2^31-1
      if (val[c][31]) begin
        mag[c] = (val[c] == 32'h8000_0000) ? 31'h7fff_ffff : 31'(-val[c]);
      end else begin
        mag[c] = val[c][30:0];
      end
      if (mag[c] > peak) begin
        peak = mag[c];
      end
    end
  end

  assign work_o.smp       = val;
  assign work_o.peak      = peak;
  assign work_o.bypass    = !cfg_i.enable;
  assign work_o.block_end = item_i.block_end;

endmodule

// ===== hw/rtl/drc_queue.sv =====
// ----------------------------------------------------------------------------
// drc_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module drc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  drc_pkg::work_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output drc_pkg::work_t data_o
);

  drc_pkg::work_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

// ===== hw/rtl/drc_back.sv =====
// ----------------------------------------------------------------------------
// drc_back
// Envelope follower, gain computation with serial dividers, and per-channel
// scaling on one shared multiplier; holds the output register.
// ----------------------------------------------------------------------------
module drc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  drc_pkg::cfg_t      cfg_i,
  input  logic               q_empty_i,
  input  drc_pkg::work_t     q_data_i,
  output logic               q_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output drc_pkg::out_item_t out_item_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ENV1  = 4'd1;
  localparam logic [3:0] S_ENV2  = 4'd2;
  localparam logic [3:0] S_ENV3  = 4'd3;
  localparam logic [3:0] S_DIVT  = 4'd4;
  localparam logic [3:0] S_RMUL  = 4'd5;
  localparam logic [3:0] S_RINIT = 4'd6;
  localparam logic [3:0] S_RDIV  = 4'd7;
  localparam logic [3:0] S_GAIN  = 4'd8;
  localparam logic [3:0] S_TOT   = 4'd9;
  localparam logic [3:0] S_TOT2  = 4'd10;
  localparam logic [3:0] S_CHM   = 4'd11;
  localparam logic [3:0] S_CHW   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0]  state_q;
  logic [30:0] env_q;
  logic        out_valid_q;
  drc_pkg::out_item_t out_q;

  drc_pkg::work_t it_q;
  logic [drc_pkg::MaxChannels-1:0][31:0] res_q;
  logic [63:0] prod_q, acc_q;
  logic [30:0] rem_t_q;
  logic [29:0] qt_q;
  logic [36:0] n1_q, n2_q;
  logic [6:0]  rem1_q, rem2_q;
  logic [5:0]  cnt_q;
  logic [30:0] gain_q, total_q;
  logic [2:0]  ch_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [30:0] coef_raw, coef, one_minus;
  logic [63:0] env_sum;
  logic [30:0] env_new;
  logic [31:0] rem2x;
  logic [6:0]  r;
  logic [7:0]  r1x, r2x;
  logic signed [33:0] sh;
  logic [31:0] v32, vout;
  logic        out_free;

  assign r         = (cfg_i.ratio == 7'd0) ? 7'd1 : cfg_i.ratio;
  assign coef_raw  = (it_q.peak > env_q) ? cfg_i.atk_coef : cfg_i.rel_coef;
  assign coef      = (coef_raw > drc_pkg::OneQ30) ? drc_pkg::OneQ30 : coef_raw;
  assign one_minus = drc_pkg::OneQ30 - coef;
  assign env_sum   = acc_q + prod_q;
  assign env_new   = env_sum[60:30];
  assign rem2x     = {rem_t_q, 1'b0};
  assign r1x       = {rem1_q, n1_q[36]};
  assign r2x       = {rem2_q, n2_q[36]};
  assign out_free  = !out_valid_q || pop_i;

  // floor shift of the scaled sample, then saturation to the sample format
  always_comb begin
    sh = prod_q[63:30];
    if (sh > 34'sh0_7fff_ffff)       v32 = 32'h7fff_ffff;
    else if (sh < -34'sh0_8000_0000) v32 = 32'h8000_0000;
    else                             v32 = sh[31:0];
    vout = cfg_i.sample_format ? v32 : {{16{v32[31]}}, v32[31:16]};
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_ENV1: begin
        mul_a = {2'b00, coef};
        mul_b = {2'b00, env_q};
      end
      S_ENV2: begin
        mul_a = {2'b00, one_minus};
        mul_b = {2'b00, it_q.peak};
      end
      S_RMUL: begin
        mul_a = 33'(r - 7'd1);
        mul_b = 33'(qt_q);
      end
      S_TOT: begin
        mul_a = {2'b00, gain_q};
        mul_b = {2'b00, cfg_i.makeup};
      end
      S_CHM: begin
        mul_a = {it_q.smp[ch_q][31], it_q.smp[ch_q]};
        mul_b = {2'b00, total_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign q_pop_o = (state_q == S_IDLE) && !q_empty_i;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p[63:0];
    case (state_q)
      S_IDLE: begin
        it_q  <= q_data_i;
        res_q <= q_data_i.smp;
      end
      S_ENV2: acc_q <= prod_q;
      S_ENV3: begin
        rem_t_q <= cfg_i.threshold;
        qt_q    <= '0;
        gain_q  <= drc_pkg::OneQ30;
      end
      S_DIVT: begin
        if (rem2x >= {1'b0, env_q}) begin
          rem_t_q <= 31'(rem2x - {1'b0, env_q});
          qt_q    <= {qt_q[28:0], 1'b1};
        end else begin
          rem_t_q <= rem2x[30:0];
          qt_q    <= {qt_q[28:0], 1'b0};
        end
      end
      S_RINIT: begin
        n1_q   <= 37'(drc_pkg::OneQ30);
        n2_q   <= prod_q[36:0];
        rem1_q <= '0;
        rem2_q <= '0;
      end
      S_RDIV: begin
        if (r1x >= {1'b0, r}) begin
          rem1_q <= 7'(r1x - {1'b0, r});
          n1_q   <= {n1_q[35:0], 1'b1};
        end else begin
          rem1_q <= r1x[6:0];
          n1_q   <= {n1_q[35:0], 1'b0};
        end
        if (r2x >= {1'b0, r}) begin
          rem2_q <= 7'(r2x - {1'b0, r});
          n2_q   <= {n2_q[35:0], 1'b1};
        end else begin
          rem2_q <= r2x[6:0];
          n2_q   <= {n2_q[35:0], 1'b0};
        end
      end
      S_GAIN: gain_q  <= n1_q[30:0] + n2_q[30:0];
      S_TOT2: total_q <= prod_q[60:30];
      S_CHW:  res_q[ch_q] <= vout;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      env_q       <= '0;
      cnt_q       <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            state_q <= q_data_i.bypass ? S_OUT : S_ENV1;
          end
        end
        S_ENV1: state_q <= S_ENV2;
        S_ENV2: state_q <= S_ENV3;
        S_ENV3: begin
          env_q <= env_new;
          cnt_q <= 6'd30;
          // env above threshold implies env nonzero
          state_q <= (env_new > cfg_i.threshold) ? S_DIVT : S_TOT;
        end
        S_DIVT: begin
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) state_q <= S_RMUL;
        end
        S_RMUL: state_q <= S_RINIT;
        S_RINIT: begin
          cnt_q   <= 6'd37;
          state_q <= S_RDIV;
        end
        S_RDIV: begin
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) state_q <= S_GAIN;
        end
        S_GAIN: state_q <= S_TOT;
        S_TOT:  state_q <= S_TOT2;
        S_TOT2: begin
          ch_q    <= '0;
          state_q <= S_CHM;
        end
        S_CHM: state_q <= S_CHW;
        S_CHW: begin
          ch_q    <= ch_q + 3'd1;
          state_q <= (ch_q == 3'(drc_pkg::MaxChannels - 1)) ? S_OUT : S_CHM;
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_q.out_sample_0  <= res_q[0];
      out_q.out_sample_1  <= res_q[1];
      out_q.out_sample_2  <= res_q[2];
      out_q.out_sample_3  <= res_q[3];
      out_q.out_sample_4  <= res_q[4];
      out_q.out_sample_5  <= res_q[5];
      out_q.out_sample_6  <= res_q[6];
      out_q.out_sample_7  <= res_q[7];
      out_q.block_end_out <= it_q.block_end;
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

endmodule

// ===== hw/rtl/dynamic_range_compressor.sv =====
// If the envelope ends above threshold, the 30-step threshold and 37-step ratio
// dividers run; a pass-through frame skips all processing. One shared multiplier
// serves envelope, gain and 8 channels. A frame is done before the next is popped;
// a two-entry queue decouples input from processing.
// Reset: envelope cleared, registers at defaults, queue and output empty.
// ----------------------------------------------------------------------------
// dynamic_range_compressor
// Feed-forward peak compressor for multichannel audio frames.
// ----------------------------------------------------------------------------
module dynamic_range_compressor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  drc_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output drc_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  drc_pkg::cfg_t  cfg_q;
  drc_pkg::work_t f_work, q_data;
  logic q_full, q_empty, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold     <= 31'd536870912;
      cfg_q.ratio         <= 7'd4;
      cfg_q.atk_coef      <= 31'd1072693248;
      cfg_q.rel_coef      <= 31'd1073635328;
      cfg_q.makeup        <= 31'd1073741824;
      cfg_q.channel_count <= 4'd2;
      cfg_q.enable        <= 1'b1;
      cfg_q.sample_format <= 1'b1;
    end else if (cfg_valid_i) begin
      case (drc_pkg::cfg_reg_e'(cfg_index_i))
        drc_pkg::REG_THRESHOLD:     cfg_q.threshold     <= cfg_data_i[30:0];
        drc_pkg::REG_RATIO:         cfg_q.ratio         <= cfg_data_i[6:0];
        drc_pkg::REG_ATTACK:        cfg_q.atk_coef      <= cfg_data_i[30:0];
        drc_pkg::REG_RELEASE:       cfg_q.rel_coef      <= cfg_data_i[30:0];
        drc_pkg::REG_MAKEUP:        cfg_q.makeup        <= cfg_data_i[30:0];
        drc_pkg::REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data_i[3:0];
        drc_pkg::REG_ENABLE:        cfg_q.enable        <= cfg_data_i[0];
        drc_pkg::REG_SAMPLE_FORMAT: cfg_q.sample_format <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  drc_front u_front (
    .cfg_i  (cfg_q),
    .item_i (in_item_i),
    .work_o (f_work)
  );

  assign full = q_full;

  drc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && !q_full),
    .data_i  (f_work),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_data)
  );

  drc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (q_empty),
    .q_data_i   (q_data),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

endmodule

// ===== test/dynamic_range_compressor_test.sv =====
// ----------------------------------------------------------------------------
// dynamic_range_compressor_test
// Self-checking bench: a directed table of frames, then phases of random
// frames under varied register settings and handshake pressure, every output frame
// checked against a fixed expected frame or an in-bench model of the compressor.
// ----------------------------------------------------------------------------
module dynamic_range_compressor_test;

  localparam longint OneQ30l   = 64'sd1073741824;
  localparam longint MaxPos    = 64'sd2147483647;
  localparam longint MinNeg    = -64'sd2147483648;
  localparam int     Phases    = 10;
  localparam int     PhaseLen  = 200;
  localparam int     DrainWait = 120;
  localparam int     DogLimit  = 20000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               push        = 1'b0;
  logic               full;
  drc_pkg::in_item_t  in_item_i   = '0;
  logic               empty;
  logic               pop         = 1'b0;
  drc_pkg::out_item_t out_item_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [3:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i  = '0;

  dynamic_range_compressor dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  drc_pkg::cfg_t      regs_q;
  logic [31:0]        envelope_q;
  drc_pkg::out_item_t pending_frames[$];
  int                 mismatches = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 quiet_cycles = 0;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    mismatches++;
  endtask

  function automatic drc_pkg::out_item_t compress_frame(input drc_pkg::in_item_t it);
    logic [31:0]        raw [8];
    longint             s [8];
    longint             res [8];
    int                 n;
    bit                 f16;
    longint             peak, a, envl, coef, gain, thr, r, term, total, v;
    drc_pkg::out_item_t o;
    raw = '{it.sample_0, it.sample_1, it.sample_2, it.sample_3,
            it.sample_4, it.sample_5, it.sample_6, it.sample_7};
    n = (regs_q.channel_count > drc_pkg::MaxChannels) ? int'(drc_pkg::MaxChannels)
                                                      : int'(regs_q.channel_count);
    f16 = !regs_q.sample_format;
    for (int c = 0; c < 8; c++) begin
      res[c] = 0;
      s[c] = f16 ? longint'(signed'(raw[c][15:0])) : longint'(signed'(raw[c]));
    end
    if (!regs_q.enable) begin
      for (int c = 0; c < n; c++) res[c] = s[c];
    end else begin
      peak = 0;
      for (int c = 0; c < n; c++) begin
        if (f16) s[c] = s[c] * 65536;
        a = (s[c] < 0) ? -s[c] : s[c];
        if (a > MaxPos) a = MaxPos;
        if (a > peak) peak = a;
      end
      envl = longint'(envelope_q);
      coef = (peak > envl) ? longint'(regs_q.atk_coef) : longint'(regs_q.rel_coef);
      if (coef > OneQ30l) coef = OneQ30l;
      envl = (coef * envl + (OneQ30l - coef) * peak) >>> 30;
      envelope_q = envl[31:0];
      gain = OneQ30l;
      thr = longint'(regs_q.threshold);
      if (envl > thr && envl > 0) begin
        r = (regs_q.ratio == 0) ? 1 : longint'(regs_q.ratio);
        term = (thr * OneQ30l) / envl;
        gain = OneQ30l / r + ((r - 1) * term) / r;
      end
      total = (gain * longint'(regs_q.makeup)) >>> 30;
      for (int c = 0; c < n; c++) begin
        v = (s[c] * total) >>> 30;
        if (v > MaxPos) v = MaxPos;
        if (v < MinNeg) v = MinNeg;
        if (f16) begin
          v = v >>> 16;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
        end
        res[c] = v;
      end
    end
    o.out_sample_0 = res[0][31:0];
    o.out_sample_1 = res[1][31:0];
    o.out_sample_2 = res[2][31:0];
    o.out_sample_3 = res[3][31:0];
    o.out_sample_4 = res[4][31:0];
    o.out_sample_5 = res[5][31:0];
    o.out_sample_6 = res[6][31:0];
    o.out_sample_7 = res[7][31:0];
    o.block_end_out = it.block_end;
    return o;
  endfunction

  // output side: random stalls, compare against oldest expected frame
  always @(posedge clk_i) begin
    drc_pkg::out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("unexpected frame, queued", 0, 0);
      end else begin
        want = pending_frames.pop_front();
        for (int c = 0; c < 8; c++)
          if (out_item_o[256-32*c -: 32] !== want[256-32*c -: 32])
            report_mismatch($sformatf("out_sample_%0d", c),
                            longint'(signed'(out_item_o[256-32*c -: 32])),
                            longint'(signed'(want[256-32*c -: 32])));
        if (out_item_o.block_end_out !== want.block_end_out)
          report_mismatch("block_end_out", out_item_o.block_end_out, want.block_end_out);
      end
    end
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= DogLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_frame(input drc_pkg::in_item_t it, input bit typed,
                            input drc_pkg::out_item_t want);
    drc_pkg::out_item_t got_pred;
    push <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full);
    got_pred = compress_frame(it);
    pending_frames.push_back(typed ? want : got_pred);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input drc_pkg::cfg_reg_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      drc_pkg::REG_THRESHOLD:     regs_q.threshold     = data[30:0];
      drc_pkg::REG_RATIO:         regs_q.ratio         = data[6:0];
      drc_pkg::REG_ATTACK:        regs_q.atk_coef      = data[30:0];
      drc_pkg::REG_RELEASE:       regs_q.rel_coef      = data[30:0];
      drc_pkg::REG_MAKEUP:        regs_q.makeup        = data[30:0];
      drc_pkg::REG_CHANNEL_COUNT: regs_q.channel_count = data[3:0];
      drc_pkg::REG_ENABLE:        regs_q.enable        = data[0];
      drc_pkg::REG_SAMPLE_FORMAT: regs_q.sample_format = data[0];
      default: ;
    endcase
  endtask

  // sender holds off until every frame is back, then lets the datapath settle
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_sample(input bit f16);
    int k;
    k = $urandom_range(9);
    if (f16) begin
      case (k)
        0: return 32'hFFFF_8000;
        1: return 32'h0000_7FFF;
        2: return $urandom;
        default: return {{16{1'b0}}, 16'($urandom)} ^ {32{$urandom_range(1) == 1}};
      endcase
    end
    case (k)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  typedef struct {
    drc_pkg::in_item_t  item;
    bit                 typed;
    drc_pkg::out_item_t want;
  } row_t;

  function automatic row_t pass_row(input logic [31:0] a, input logic [31:0] b,
                                    input bit be);
    row_t rw;
    rw.item = '0;
    rw.item.sample_0 = a;
    rw.item.sample_1 = b;
    rw.item.sample_2 = $urandom;
    rw.item.sample_7 = 32'hFFFF_FFFF;
    rw.item.block_end = be;
    rw.typed = 1'b1;
    rw.want = '0;
    rw.want.out_sample_0 = a;
    rw.want.out_sample_1 = b;
    rw.want.block_end_out = be;
    return rw;
  endfunction

  initial begin
    row_t              table_rows[$];
    row_t              rw;
    drc_pkg::in_item_t it;
    bit                f16;
    logic [31:0]       vals [8];

    regs_q = '{threshold: 31'd536870912, ratio: 7'd4, atk_coef: 31'd1072693248,
               rel_coef: 31'd1073635328, makeup: 31'd1073741824,
               channel_count: 4'd2, enable: 1'b1, sample_format: 1'b1};
    envelope_q = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: two channels, unity gain while the envelope is low
    table_rows.push_back(pass_row(32'h0, 32'h0, 1'b0));
    table_rows.push_back(pass_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
    table_rows.push_back(pass_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    table_rows.push_back(pass_row(32'h1, 32'hFFFF_FFFF, 1'b1));
    table_rows.push_back(pass_row(32'h5555_5555, 32'hAAAA_AAAA, 1'b0));
    for (int i = 0; i < 15; i++) begin
      rw.item = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, 1'($urandom)};
      if (i < 8) rw.item.sample_0 = 32'h8000_0000;
      rw.typed = 1'b0;
      rw.want = '0;
      table_rows.push_back(rw);
    end
    foreach (table_rows[i]) send_frame(table_rows[i].item, table_rows[i].typed,
                                       table_rows[i].want);

    for (int p = 0; p < Phases; p++) begin
      drain();
      case (p)
        0: vals = '{0, 64, 0, 32'h4000_0000, 32'h7FFF_FFFF, 8, 1, 1};
        1: vals = '{32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1, 1, 0};
        2: vals = '{32'h0100_0000, 0, 32'h3000_0000, 32'h3F00_0000, 32'h4000_0000,
                    0, 1, 1};
        3: vals = '{32'h0800_0000, 127, 32'h2000_0000, 32'h3FFF_0000, 32'h5000_0000,
                    15, 0, 0};
        4: vals = '{32'h0000_1000, 64, 32'h4000_0000, 0, 32'h6000_0000, 8, 1, 0};
        default: vals = '{$urandom_range(32'h4000_0000), $urandom_range(127),
                          $urandom_range(32'h4000_0000), $urandom_range(32'h4000_0000),
                          $urandom_range(32'h7FFF_FFFF), $urandom_range(15),
                          $urandom_range(9) != 0, $urandom_range(1)};
      endcase
      for (int r = 0; r < 8; r++) write_reg(drc_pkg::cfg_reg_e'(r), vals[r]);
      cfg_valid_i <= 1'b0;
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      f16 = !regs_q.sample_format;
      for (int i = 0; i < PhaseLen; i++) begin
        it = {rand_sample(f16), rand_sample(f16), rand_sample(f16), rand_sample(f16),
              rand_sample(f16), rand_sample(f16), rand_sample(f16), rand_sample(f16),
              1'($urandom)};
        send_frame(it, 1'b0, '0);
      end
    end

    push <= 1'b0;
    recv_stall_pct = 0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0 && pending_frames.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
